/* rtl/mlts_pkg.sv */
// Shared types and constants of the micro-language token scanner.
package mlts_pkg;

  localparam int LINE_BITS = 16;
  localparam int LINE_W    = 16;
  localparam int KIND_W    = 5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] TK_MAIN   = 5'd0;
  localparam logic [KIND_W-1:0] TK_LCURL  = 5'd1;
  localparam logic [KIND_W-1:0] TK_RCURL  = 5'd2;
  localparam logic [KIND_W-1:0] TK_ASSIGN = 5'd3;
  localparam logic [KIND_W-1:0] TK_READ   = 5'd4;
  localparam logic [KIND_W-1:0] TK_WRITE  = 5'd5;
  localparam logic [KIND_W-1:0] TK_IF     = 5'd6;
  localparam logic [KIND_W-1:0] TK_ELSE   = 5'd7;
  localparam logic [KIND_W-1:0] TK_WHILE  = 5'd8;
  localparam logic [KIND_W-1:0] TK_PLUS   = 5'd9;
  localparam logic [KIND_W-1:0] TK_MINUS  = 5'd10;
  localparam logic [KIND_W-1:0] TK_MUL    = 5'd11;
  localparam logic [KIND_W-1:0] TK_DIV    = 5'd12;
  localparam logic [KIND_W-1:0] TK_LPAREN = 5'd13;
  localparam logic [KIND_W-1:0] TK_RPAREN = 5'd14;
  localparam logic [KIND_W-1:0] TK_LT     = 5'd15;
  localparam logic [KIND_W-1:0] TK_GT     = 5'd16;
  localparam logic [KIND_W-1:0] TK_EQUAL  = 5'd17;
  localparam logic [KIND_W-1:0] TK_LE     = 5'd18;
  localparam logic [KIND_W-1:0] TK_GE     = 5'd19;
  localparam logic [KIND_W-1:0] TK_NE     = 5'd20;
  localparam logic [KIND_W-1:0] TK_SEMI   = 5'd21;
  localparam logic [KIND_W-1:0] TK_COMMA  = 5'd22;
  localparam logic [KIND_W-1:0] TK_EOF    = 5'd23;
  localparam logic [KIND_W-1:0] TK_IDENT  = 5'd24;
  localparam logic [KIND_W-1:0] TK_INT    = 5'd25;
  localparam logic [KIND_W-1:0] TK_ERR    = 5'd26;

  // One queue entry: the one or two tokens that a single character produced.
  typedef struct packed {
    logic              two;
    logic [KIND_W-1:0] kind0;
    logic [KIND_W-1:0] kind1;
    logic [LINE_W-1:0] line;
  } mlts_entry_t;

  typedef struct packed {
    logic        valid;
    mlts_entry_t entry;
  } mlts_push_t;

endpackage

/* rtl/mlts_front.sv */
// Front end: accepts characters, tracks the scan mode and forms token entries.
module mlts_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               char_code_i,
  input  logic                     end_of_file_i,
  input  logic                     full_i,
  output mlts_pkg::mlts_push_t     push_o
);

  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_WORD    = 4'd1;
  localparam logic [3:0] MODE_NUMBER  = 4'd2;
  localparam logic [3:0] MODE_GT      = 4'd3;
  localparam logic [3:0] MODE_LT      = 4'd4;
  localparam logic [3:0] MODE_BANG    = 4'd5;
  localparam logic [3:0] MODE_COLON   = 4'd6;
  localparam logic [3:0] MODE_SLASH   = 4'd7;
  localparam logic [3:0] MODE_COMMENT = 4'd8;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LCURL  = 8'h7B;
  localparam logic [7:0] CH_RCURL  = 8'h7D;

  localparam int NKEY = 6;
  localparam logic [NKEY-1:0][2:0] KW_LEN =
    {3'd5, 3'd4, 3'd5, 3'd4, 3'd2, 3'd4};
  localparam logic [NKEY-1:0][mlts_pkg::KIND_W-1:0] KW_CODE =
    {mlts_pkg::TK_WRITE, mlts_pkg::TK_READ, mlts_pkg::TK_WHILE,
     mlts_pkg::TK_ELSE, mlts_pkg::TK_IF, mlts_pkg::TK_MAIN};
  localparam logic [mlts_pkg::LINE_BITS-1:0] LINE_MAX = '1;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Character at position pos of keyword k; the strings are written last
  // character first, so that element 0 is the first character.
  function automatic logic [7:0] kw_char(int k, logic [2:0] pos);
    logic [7:0][7:0] t;
    t = '0;
    case (k)
      0:       t[3:0] = "niam";
      1:       t[1:0] = "fi";
      2:       t[3:0] = "esle";
      3:       t[4:0] = "elihw";
      4:       t[3:0] = "daer";
      default: t[4:0] = "etirw";
    endcase
    return t[pos];
  endfunction

  function automatic logic [NKEY-1:0] narrow(logic [NKEY-1:0] cand, logic [2:0] wlen,
                                             logic [7:0] c);
    logic [NKEY-1:0] keep;
    keep = '0;
    for (int k = 0; k < NKEY; k++) begin
      if (cand[k] && wlen < KW_LEN[k] && kw_char(k, wlen) == c) begin
        keep[k] = 1'b1;
      end
    end
    return keep;
  endfunction

  function automatic logic [mlts_pkg::KIND_W-1:0] word_kind(logic [NKEY-1:0] cand,
                                                           logic [2:0] wlen);
    logic [mlts_pkg::KIND_W-1:0] kind;
    kind = mlts_pkg::TK_IDENT;
    for (int k = NKEY - 1; k >= 0; k--) begin
      if (cand[k] && wlen == KW_LEN[k]) begin
        kind = KW_CODE[k];
      end
    end
    return kind;
  endfunction

  logic [3:0]                         mode_q, mode_d;
  logic [NKEY-1:0]                    cand_q, cand_d;
  logic [2:0]                         wlen_q, wlen_d;
  logic [mlts_pkg::LINE_BITS-1:0]     line_q, line_d;

  logic                               accept;
  logic [7:0]                         c;
  logic                               eof;
  logic                               eq;

  logic                               idle_emit;
  logic [mlts_pkg::KIND_W-1:0]        idle_kind;
  logic [3:0]                         idle_mode;
  logic                               idle_nl;
  logic                               idle_word;

  logic                               pre_emit;
  logic [mlts_pkg::KIND_W-1:0]        pre_kind;
  logic                               apply_idle;
  logic                               nl_count;

  assign c          = char_code_i;
  assign eof        = end_of_file_i;
  assign eq         = !eof && c == CH_EQUAL;
  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  // Classification of a character scanned from the idle mode.
  always_comb begin
    idle_emit = 1'b0;
    idle_kind = mlts_pkg::TK_ERR;
    idle_mode = MODE_IDLE;
    idle_nl   = 1'b0;
    idle_word = 1'b0;
    if (eof) begin
      idle_emit = 1'b1;
      idle_kind = mlts_pkg::TK_EOF;
    end else if (is_space(c)) begin
      idle_nl = c == CH_NL;
    end else if (is_letter(c)) begin
      idle_word = 1'b1;
      idle_mode = MODE_WORD;
    end else if (is_digit(c)) begin
      idle_mode = MODE_NUMBER;
    end else begin
      unique case (c)
        CH_GREAT:  idle_mode = MODE_GT;
        CH_LESS:   idle_mode = MODE_LT;
        CH_BANG:   idle_mode = MODE_BANG;
        CH_COLON:  idle_mode = MODE_COLON;
        CH_SLASH:  idle_mode = MODE_SLASH;
        CH_LCURL:  begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_LCURL;  end
        CH_RCURL:  begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_RCURL;  end
        CH_LPAREN: begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_LPAREN; end
        CH_RPAREN: begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_RPAREN; end
        CH_COMMA:  begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_COMMA;  end
        CH_SEMI:   begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_SEMI;   end
        CH_STAR:   begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_MUL;    end
        CH_MINUS:  begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_MINUS;  end
        CH_PLUS:   begin idle_emit = 1'b1; idle_kind = mlts_pkg::TK_PLUS;   end
        default:   idle_emit = 1'b1;
      endcase
    end
  end

  // Mode handling: a token may be closed first, and then the same character
  // is scanned again from idle.
  always_comb begin
    mode_d     = mode_q;
    cand_d     = cand_q;
    wlen_d     = wlen_q;
    pre_emit   = 1'b0;
    pre_kind   = mlts_pkg::TK_ERR;
    apply_idle = 1'b0;
    nl_count   = 1'b0;

    unique case (mode_q) inside
      MODE_WORD: begin
        if (!eof && (is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
          cand_d = narrow(cand_q, wlen_q, c);
          wlen_d = (wlen_q != 3'd7) ? wlen_q + 3'd1 : wlen_q;
        end else begin
          pre_emit   = 1'b1;
          pre_kind   = word_kind(cand_q, wlen_q);
          apply_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (eof || !is_digit(c)) begin
          pre_emit   = 1'b1;
          pre_kind   = mlts_pkg::TK_INT;
          apply_idle = 1'b1;
        end
      end
      MODE_GT, MODE_LT, MODE_BANG, MODE_COLON: begin
        pre_emit = 1'b1;
        if (eq) begin
          mode_d = MODE_IDLE;
          case (mode_q)
            MODE_GT: pre_kind = mlts_pkg::TK_GE;
            MODE_LT: pre_kind = mlts_pkg::TK_LE;
            MODE_BANG: pre_kind = mlts_pkg::TK_NE;
            default: pre_kind = mlts_pkg::TK_ASSIGN;
          endcase
        end else begin
          apply_idle = 1'b1;
          case (mode_q)
            MODE_GT: pre_kind = mlts_pkg::TK_GT;
            MODE_LT: pre_kind = mlts_pkg::TK_LT;
            default: pre_kind = mlts_pkg::TK_ERR;
          endcase
        end
      end
      MODE_SLASH: begin
        if (!eof && c == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          pre_emit   = 1'b1;
          pre_kind   = mlts_pkg::TK_DIV;
          apply_idle = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (eof) begin
          apply_idle = 1'b1;
        end else if (c == CH_NL) begin
          nl_count = 1'b1;
          mode_d   = MODE_IDLE;
        end
      end
      default: apply_idle = 1'b1;
    endcase

    if (apply_idle) begin
      mode_d = idle_mode;
      if (idle_word) begin
        cand_d = narrow('1, 3'd0, c);
        wlen_d = 3'd1;
      end
    end
  end

  always_comb begin
    line_d = line_q;
    if ((nl_count || (apply_idle && idle_nl)) && line_q != LINE_MAX) begin
      line_d = line_q + 1'b1;
    end
  end

  // Tokens are stamped with the line count before this character's update.
  always_comb begin
    push_o.entry.line = mlts_pkg::LINE_W'(line_q);
    if (pre_emit) begin
      push_o.valid       = accept;
      push_o.entry.kind0 = pre_kind;
      push_o.entry.kind1 = idle_kind;
      push_o.entry.two   = apply_idle && idle_emit;
    end else begin
      push_o.valid       = accept && apply_idle && idle_emit;
      push_o.entry.kind0 = idle_kind;
      push_o.entry.kind1 = idle_kind;
      push_o.entry.two   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cand_q <= '0;
      wlen_q <= '0;
      line_q <= mlts_pkg::LINE_BITS'(1);
    end else if (accept) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      wlen_q <= wlen_d;
      line_q <= line_d;
    end
  end

endmodule

/* rtl/mlts_queue.sv */
// Short queue of token entries between the front end and the output stage.
module mlts_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mlts_pkg::mlts_push_t  push_i,
  output logic                  full_o,
  output logic                  valid_o,
  output mlts_pkg::mlts_entry_t entry_o,
  input  logic                  pop_i
);

  mlts_pkg::mlts_entry_t          mem_q [mlts_pkg::QDEPTH];
  logic [mlts_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [mlts_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [mlts_pkg::QCNT_W-1:0]    count_q;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = count_q == mlts_pkg::QCNT_W'(mlts_pkg::QDEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/mlts_back.sv */
// Output stage: holds one entry and hands out its tokens one word at a time.
module mlts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  mlts_pkg::mlts_entry_t         q_entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mlts_pkg::KIND_W-1:0]   token_kind_o,
  output logic [mlts_pkg::LINE_W-1:0]   line_number_o,
  output logic                          last_of_run_o
);

  mlts_pkg::mlts_entry_t ent_q;
  logic                  busy_q;
  logic                  second_q;
  logic                  take;
  logic                  last;

  assign last          = second_q || !ent_q.two;
  assign take          = busy_q && !out_stall_i;
  assign pop_o         = q_valid_i && (!busy_q || (take && last));
  assign out_valid_o   = busy_q;
  assign token_kind_o  = second_q ? ent_q.kind1 : ent_q.kind0;
  assign line_number_o = ent_q.line;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= q_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      second_q <= 1'b0;
    end else if (pop_o) begin
      busy_q   <= 1'b1;
      second_q <= 1'b0;
    end else if (take && last) begin
      busy_q   <= 1'b0;
      second_q <= 1'b0;
    end else if (take) begin
      second_q <= 1'b1;
    end
  end

endmodule

/* rtl/micro_language_token_scanner_core.sv */
// Top level of the micro-language token scanner.
// The scanner takes one source character (or an end-of-file mark) per word and
// returns the tokens of a small language: keywords, identifiers, integers,
// operators and punctuation, each stamped with its line number, with comments
// and whitespace dropped. A character can close one token and start or form
// another, so it yields zero, one or two result words; last_of_run_o marks the
// final word from each character. The front end takes a character every cycle
// while its four-entry token queue has room, and the output stage delivers one
// result word per cycle while out_stall_i is low. With the output stage free, a
// token is written into the queue when the character completing it is taken
// and is loaded from there into the output stage's entry register, from which
// it is presented.
module micro_language_token_scanner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          end_of_file_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mlts_pkg::KIND_W-1:0]   token_kind_o,
  output logic [mlts_pkg::LINE_W-1:0]   line_number_o,
  output logic                          last_of_run_o
);

  mlts_pkg::mlts_push_t  push;
  mlts_pkg::mlts_entry_t head;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;

  mlts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_file_i (end_of_file_i),
    .full_i        (q_full),
    .push_o        (push)
  );

  mlts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head),
    .pop_i   (q_pop)
  );

  mlts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* rtl/mlts_checker.sv */
// Port-level checks of the token scanner and their binding to the top level.
module mlts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mlts_pkg::KIND_W-1:0]   token_kind_o,
  input logic [mlts_pkg::LINE_W-1:0]   line_number_o,
  input logic                          last_of_run_o
);

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(line_number_o) && $stable(last_of_run_o))
    else $error("stalled result word changed");

  // The second token of a character is ready straight after the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_of_run_o |=> out_valid_o && last_of_run_o)
    else $error("second token of a character not presented next");

  // Both tokens of one character carry the same line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_of_run_o |=> line_number_o == $past(line_number_o))
    else $error("line changed within one character's tokens");

  // Lines start at one, kinds stay within the code range and TK_EQUAL never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != '0 && token_kind_o <= mlts_pkg::TK_ERR &&
    token_kind_o != mlts_pkg::TK_EQUAL)
    else $error("result word out of range");

  // The input is only held off while a result word is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result word waiting");

endmodule

bind micro_language_token_scanner_core mlts_checker u_mlts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .token_kind_o  (token_kind_o),
  .line_number_o (line_number_o),
  .last_of_run_o (last_of_run_o)
);

/* bench/micro_language_token_scanner_core_tb.sv */
// Self-checking testbench for the micro-language token scanner core.
module micro_language_token_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CHARS = 1700;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NUMBER, M_GT, M_LT, M_BANG, M_COLON, M_SLASH, M_COMMENT
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
  } src_char_t;

  typedef struct packed {
    logic [mlts_pkg::KIND_W-1:0] kind;
    logic [mlts_pkg::LINE_W-1:0] line;
    logic                        last;
  } due_token_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  char_code_i = 8'h00;
  logic                        end_of_file_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [mlts_pkg::KIND_W-1:0] token_kind_o;
  logic [mlts_pkg::LINE_W-1:0] line_number_o;
  logic                        last_of_run_o;

  micro_language_token_scanner_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  src_char_t  pending_chars[$];
  due_token_t due_tokens[$];

  int unsigned tail_len = 150;
  int unsigned chars_total = 0;
  int unsigned chars_taken = 0;
  int unsigned tokens_seen = 0;
  int unsigned lex_errors_seen = 0;
  int unsigned err_cnt = 0;
  logic [mlts_pkg::LINE_W-1:0] top_line = '0;
  bit in_took = 1'b0;
  bit long_hold = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_quiet = 0;
  int unsigned stall_left = 0;
  int unsigned recv_quiet = 0;

  // Scanner state as predicted.
  scan_mode_e                     scan_mode_q = M_IDLE;
  logic [5:0]                     kw_cand = '0;
  logic [2:0]                     word_len = '0;
  logic [mlts_pkg::LINE_BITS-1:0] line_cnt = mlts_pkg::LINE_BITS'(1);
  logic [mlts_pkg::KIND_W-1:0]    step_kind [2];
  logic [mlts_pkg::LINE_W-1:0]    step_line [2];
  int                             step_n;

  function automatic string kw_word(input int k);
    case (k)
      0: return "main";
      1: return "if";
      2: return "else";
      3: return "while";
      4: return "read";
      default: return "write";
    endcase
  endfunction

  function automatic logic [mlts_pkg::KIND_W-1:0] kw_kind(input int k);
    case (k)
      0: return mlts_pkg::TK_MAIN;
      1: return mlts_pkg::TK_IF;
      2: return mlts_pkg::TK_ELSE;
      3: return mlts_pkg::TK_WHILE;
      4: return mlts_pkg::TK_READ;
      default: return mlts_pkg::TK_WRITE;
    endcase
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void emit_token(input logic [mlts_pkg::KIND_W-1:0] kind);
    step_kind[step_n] = kind;
    step_line[step_n] = line_cnt[mlts_pkg::LINE_W-1:0];
    step_n++;
  endfunction

  function automatic void count_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic void narrow_candidates(input logic [7:0] c);
    logic [5:0] keep;
    string w;
    keep = '0;
    for (int k = 0; k < 6; k++) begin
      w = kw_word(k);
      if (kw_cand[k] && word_len < w.len() && w[word_len] == c) keep[k] = 1'b1;
    end
    kw_cand = keep;
    if (word_len != 3'd7) word_len = word_len + 1'b1;
  endfunction

  function automatic logic [mlts_pkg::KIND_W-1:0] word_kind();
    string w;
    for (int k = 0; k < 6; k++) begin
      w = kw_word(k);
      if (kw_cand[k] && word_len == w.len()) return kw_kind(k);
    end
    return mlts_pkg::TK_IDENT;
  endfunction

  function automatic void scan_from_idle(input logic [7:0] c, input logic eof);
    scan_mode_q = M_IDLE;
    if (eof) begin
      emit_token(mlts_pkg::TK_EOF);
    end else if (is_space(c)) begin
      if (c == 8'h0A) count_line();
    end else if (is_letter(c)) begin
      kw_cand = '1;
      word_len = '0;
      narrow_candidates(c);
      scan_mode_q = M_WORD;
    end else if (is_digit(c)) begin
      scan_mode_q = M_NUMBER;
    end else begin
      case (c)
        ">": scan_mode_q = M_GT;
        "<": scan_mode_q = M_LT;
        "!": scan_mode_q = M_BANG;
        ":": scan_mode_q = M_COLON;
        "/": scan_mode_q = M_SLASH;
        "{": emit_token(mlts_pkg::TK_LCURL);
        "}": emit_token(mlts_pkg::TK_RCURL);
        "(": emit_token(mlts_pkg::TK_LPAREN);
        ")": emit_token(mlts_pkg::TK_RPAREN);
        ",": emit_token(mlts_pkg::TK_COMMA);
        ";": emit_token(mlts_pkg::TK_SEMI);
        "*": emit_token(mlts_pkg::TK_MUL);
        "-": emit_token(mlts_pkg::TK_MINUS);
        "+": emit_token(mlts_pkg::TK_PLUS);
        default: emit_token(mlts_pkg::TK_ERR);
      endcase
    end
  endfunction

  // Advances the predicted scanner by one character and queues the tokens it yields.
  function automatic void scan_char(input logic [7:0] c, input logic eof);
    due_token_t tok;
    step_n = 0;
    case (scan_mode_q) inside
      M_WORD: begin
        if (!eof && (is_letter(c) || is_digit(c) || c == "_")) begin
          narrow_candidates(c);
        end else begin
          emit_token(word_kind());
          scan_from_idle(c, eof);
        end
      end
      M_NUMBER: begin
        if (eof || !is_digit(c)) begin
          emit_token(mlts_pkg::TK_INT);
          scan_from_idle(c, eof);
        end
      end
      M_GT, M_LT, M_BANG, M_COLON: begin
        if (!eof && c == "=") begin
          case (scan_mode_q)
            M_GT: emit_token(mlts_pkg::TK_GE);
            M_LT: emit_token(mlts_pkg::TK_LE);
            M_BANG: emit_token(mlts_pkg::TK_NE);
            default: emit_token(mlts_pkg::TK_ASSIGN);
          endcase
          scan_mode_q = M_IDLE;
        end else begin
          case (scan_mode_q)
            M_GT: emit_token(mlts_pkg::TK_GT);
            M_LT: emit_token(mlts_pkg::TK_LT);
            default: emit_token(mlts_pkg::TK_ERR);
          endcase
          scan_from_idle(c, eof);
        end
      end
      M_SLASH: begin
        if (!eof && c == "/") begin
          scan_mode_q = M_COMMENT;
        end else begin
          emit_token(mlts_pkg::TK_DIV);
          scan_from_idle(c, eof);
        end
      end
      M_COMMENT: begin
        if (eof) begin
          scan_from_idle(c, eof);
        end else if (c == 8'h0A) begin
          count_line();
          scan_mode_q = M_IDLE;
        end
      end
      default: scan_from_idle(c, eof);
    endcase
    for (int i = 0; i < step_n; i++) begin
      tok.kind = step_kind[i];
      tok.line = step_line[i];
      tok.last = (i == step_n - 1);
      due_tokens.push_back(tok);
    end
  endfunction

  // Stimulus helpers.
  task automatic put_byte(input logic [7:0] b);
    pending_chars.push_back({b, 1'b0});
  endtask

  task automatic put_eof();
    pending_chars.push_back({8'($urandom_range(0, 255)), 1'b1});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(48, 57));
      1: return "_";
      default: return rand_letter();
    endcase
  endfunction

  // Mostly well-formed source text, with some noise mixed in.
  task automatic add_lexeme();
    string w;
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      w = kw_word($urandom_range(0, 5));
      case ($urandom_range(0, 5))
        0: put_text(w.substr(0, w.len() - 2));
        1: begin
          put_text(w);
          put_byte(rand_word_char());
        end
        2: begin
          put_byte(w[0] - 8'd32);
          put_text(w.substr(1, w.len() - 1));
        end
        default: put_text(w);
      endcase
    end else if (pick < 30) begin
      put_byte(rand_letter());
      repeat ($urandom_range(0, 9)) put_byte(rand_word_char());
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(48, 57)));
    end else if (pick < 65) begin
      case ($urandom_range(0, 15))
        0: put_text("{");
        1: put_text("}");
        2: put_text(":=");
        3: put_text("+");
        4: put_text("-");
        5: put_text("*");
        6: put_text("/");
        7: put_text("(");
        8: put_text(")");
        9: put_text("<");
        10: put_text(">");
        11: put_text("<=");
        12: put_text(">=");
        13: put_text("!=");
        14: put_text(";");
        default: put_text(",");
      endcase
    end else if (pick < 73) begin
      put_text("//");
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 255));
        put_byte(b == 8'h0A ? 8'h20 : b);
      end
      if ($urandom_range(0, 9) == 0) put_eof();
      else put_byte(8'h0A);
    end else if (pick < 80) begin
      put_byte(8'h0A);
    end else if (pick < 92) begin
      put_byte($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
    end else begin
      case ($urandom_range(0, 7))
        0: put_byte(8'($urandom_range(0, 255)));
        1: put_byte("!");
        2: put_byte(":");
        3: put_byte("=");
        4: put_byte("_");
        5: put_byte(8'h7F);
        6: put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(14, 31)));
        default: put_eof();
      endcase
    end
    if ($urandom_range(0, 1)) put_byte(" ");
  endtask

  // Sender: a new word is offered only once the previous one has been taken.
  always @(negedge clk_i) begin
    src_char_t item;
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          item = pending_chars.pop_front();
          in_valid_i <= 1'b1;
          char_code_i <= item.ch;
          end_of_file_i <= item.eof;
          if (send_quiet != 0) begin
            send_quiet--;
          end else if (pending_chars.size() > tail_len) begin
            if ($urandom_range(0, 39) == 0) send_quiet = $urandom_range(20, 80);
            else if ($urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
      end else if (recv_quiet != 0) begin
        recv_quiet--;
      end else if (pending_chars.size() > tail_len) begin
        if ($urandom_range(0, 59) == 0) recv_quiet = $urandom_range(20, 80);
        else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
      out_stall_i <= long_hold || stall_left != 0;
    end
  end

  always @(posedge clk_i) begin
    due_token_t want;
    if (rst_ni) begin
      in_took = in_valid_i && !in_stall_o;
      if (in_took) begin
        scan_char(char_code_i, end_of_file_i);
        chars_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        tokens_seen++;
        if (token_kind_o == mlts_pkg::TK_ERR) lex_errors_seen++;
        if (line_number_o > top_line) top_line = line_number_o;
        if (due_tokens.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected token kind %0d line %0d last %0d", $realtime,
                   token_kind_o, line_number_o, last_of_run_o);
        end else begin
          want = due_tokens.pop_front();
          if (token_kind_o !== want.kind) begin
            err_cnt++;
            $display("%0t: token_kind expected %0d actual %0d", $realtime, want.kind,
                     token_kind_o);
          end
          if (line_number_o !== want.line) begin
            err_cnt++;
            $display("%0t: line_number expected %0d actual %0d", $realtime, want.line,
                     line_number_o);
          end
          if (last_of_run_o !== want.last) begin
            err_cnt++;
            $display("%0t: last_of_run expected %0d actual %0d", $realtime, want.last,
                     last_of_run_o);
          end
        end
      end
    end
  end

  // Hold the output long enough for the token queue to fill and back up the input.
  initial begin
    wait (chars_taken >= 600);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    // Directed part: operators, comments, invalid codes, stray bang and colon,
    // lone equals, leading underscore, and end of file in various positions.
    put_text("if a<=0>=9!=b:=c<d>e/f//x\n");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h7F);
    put_text("!x:y=_a");
    put_eof();
    put_text("ab");
    put_eof();
    put_text("//c");
    put_eof();
    put_eof();
    put_text("!");
    put_eof();

    while (pending_chars.size() < RANDOM_CHARS) add_lexeme();

    // A few tokens to close the source, then end of file.
    put_text("x 7;");
    put_eof();
    chars_total = pending_chars.size();

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    wait (chars_taken == chars_total);
    wait (due_tokens.size() == 0);
    repeat (10) @(posedge clk_i);

    $display("Scanned %0d characters into %0d tokens (%0d lexical errors).",
             chars_taken, tokens_seen, lex_errors_seen);
    $display("Highest line number reported: %0d.", top_line);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mlts_pkg.sv
rtl/mlts_front.sv
rtl/mlts_queue.sv
rtl/mlts_back.sv
rtl/micro_language_token_scanner_core.sv
rtl/mlts_checker.sv
bench/micro_language_token_scanner_core_tb.sv
